FILE: rtl/core/c_escape_unescape_assert.svh
// assertion macros for the escape decoder, empty under synthesis
`ifndef C_ESCAPE_UNESCAPE_ASSERT_SVH
`define C_ESCAPE_UNESCAPE_ASSERT_SVH
`ifndef SYNTHESIS
`define CEU_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CEU_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CEU_ASSERT(lbl, clk, rst_n, prop, msg)
`define CEU_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

FILE: rtl/core/ceu_pkg.sv
// shared types, codes and the escape letter table of the escape decoder
package ceu_pkg;

  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHAR_ZERO      = 8'h30;
  localparam logic [7:0] CHAR_SEVEN     = 8'h37;
  localparam logic [7:0] CHAR_NUL       = 8'h00;
  localparam int unsigned QDEPTH        = 4;

  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_ESC   = 2'd1,
    MODE_OCT1  = 2'd2,
    MODE_OCT2  = 2'd3
  } mode_t;

  typedef struct packed {
    logic [7:0] data;
    logic       eos;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } dec_out_t;

  function automatic logic is_octal(input logic [7:0] b);
    is_octal = (b >= CHAR_ZERO) && (b <= CHAR_SEVEN);
  endfunction

  function automatic logic [7:0] escape_code(input logic [7:0] b);
    unique case (b)
      8'h61:   escape_code = 8'd7;
      8'h62:   escape_code = 8'd8;
      8'h66:   escape_code = 8'd12;
      8'h6E:   escape_code = 8'd10;
      8'h72:   escape_code = 8'd13;
      8'h74:   escape_code = 8'd9;
      8'h76:   escape_code = 8'd11;
      default: escape_code = b;
    endcase
  endfunction

endpackage

FILE: rtl/core/ceu_decode.sv
// escape parser: mode and octal registers, one byte decided per beat
module ceu_decode (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [7:0]        in_data,
  output ceu_pkg::dec_out_t dec
);
  import ceu_pkg::*;

  mode_t      mode_r, mode_nxt;
  logic [7:0] acc_r, acc_nxt;
  logic [7:0] oct_v;

  assign oct_v = {acc_r[4:0], in_data[2:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_PLAIN;
      acc_r  <= '0;
    end else if (fire) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
    end
  end

  // next state
  always_comb begin
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    unique case (mode_r)
      MODE_PLAIN: begin
        if (in_data == CHAR_NUL) begin
          acc_nxt = '0;
        end else if (in_data == CHAR_BACKSLASH) begin
          mode_nxt = MODE_ESC;
        end
      end
      MODE_ESC: begin
        if (in_data == CHAR_NUL) begin
          mode_nxt = MODE_PLAIN;
          acc_nxt  = '0;
        end else if (is_octal(in_data)) begin
          mode_nxt = MODE_OCT1;
          acc_nxt  = {5'd0, in_data[2:0]};
        end else begin
          mode_nxt = MODE_PLAIN;
        end
      end
      MODE_OCT1, MODE_OCT2: begin
        if (is_octal(in_data) && mode_r == MODE_OCT1) begin
          mode_nxt = MODE_OCT2;
          acc_nxt  = oct_v;
        end else begin
          acc_nxt  = '0;
          mode_nxt = (!is_octal(in_data) && in_data == CHAR_BACKSLASH) ? MODE_ESC : MODE_PLAIN;
        end
      end
      default: begin
        mode_nxt = MODE_PLAIN;
        acc_nxt  = '0;
      end
    endcase
  end

  // results
  always_comb begin
    dec = '0;
    unique case (mode_r)
      MODE_PLAIN: begin
        if (in_data == CHAR_NUL) begin
          dec.cnt = 2'd1;
          dec.r0  = '{data: CHAR_NUL, eos: 1'b1, last: 1'b1};
        end else if (in_data != CHAR_BACKSLASH) begin
          dec.cnt = 2'd1;
          dec.r0  = '{data: in_data, eos: 1'b0, last: 1'b1};
        end
      end
      MODE_ESC: begin
        if (in_data == CHAR_NUL) begin
          dec.cnt = 2'd1;
          dec.r0  = '{data: CHAR_NUL, eos: 1'b1, last: 1'b1};
        end else if (!is_octal(in_data)) begin
          dec.cnt = 2'd1;
          dec.r0  = '{data: escape_code(in_data), eos: 1'b0, last: 1'b1};
        end
      end
      MODE_OCT1, MODE_OCT2: begin
        if (is_octal(in_data)) begin
          if (mode_r == MODE_OCT2) begin
            dec.cnt = 2'd1;
            dec.r0  = '{data: oct_v, eos: 1'b0, last: 1'b1};
          end
        end else if (in_data == CHAR_BACKSLASH) begin
          dec.cnt = 2'd1;
          dec.r0  = '{data: acc_r, eos: 1'b0, last: 1'b1};
        end else begin
          dec.cnt = 2'd2;
          dec.r0  = '{data: acc_r, eos: 1'b0, last: 1'b0};
          dec.r1  = '{data: in_data, eos: (in_data == CHAR_NUL), last: 1'b1};
        end
      end
      default: dec = '0;
    endcase
  end

endmodule

FILE: rtl/core/ceu_outq.sv
// result queue: takes up to two results per beat, hands out one per beat
module ceu_outq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ceu_pkg::dec_out_t dec,
  output logic              room,
  output logic              out_valid,
  input  logic              out_stall,
  output ceu_pkg::res_t     out_res
);
  import ceu_pkg::*;

  localparam int unsigned PW = $clog2(QDEPTH);
  localparam int unsigned CW = $clog2(QDEPTH + 1);

  res_t          q_r [QDEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic [PW-1:0] wr_ptr1;
  logic [1:0]    n_push;
  logic          pop;

  assign n_push    = push ? dec.cnt : 2'd0;
  assign pop       = out_valid && !out_stall;
  assign out_valid = (cnt_r != '0);
  assign room      = (cnt_r <= CW'(QDEPTH - 2));
  assign out_res   = q_r[rd_ptr_r];
  assign wr_ptr1   = wr_ptr_r + PW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PW'(n_push);
      rd_ptr_r <= rd_ptr_r + PW'(pop);
      cnt_r    <= cnt_r + CW'(n_push) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      q_r[wr_ptr_r] <= dec.r0;
    end
    if (n_push == 2'd2) begin
      q_r[wr_ptr1] <= dec.r1;
    end
  end

endmodule

FILE: rtl/core/c_escape_unescape.sv
// top level of the C string escape decoder
//
// input channel: in_valid / in_stall carry one string byte per beat in
// in_byte; a zero byte ends the string. result channel: out_valid /
// out_stall carry one decoded byte per beat with out_end_of_string on the
// terminator and out_last_of_run on the last result of an input byte.
// an input byte gives zero, one or two results.
// a result passes the input register, then decode into a four-entry result
// queue, before it is offered on the result channel.
// throughput: one input byte per cycle while results drain; a byte that
// gives two results sends both through the single-result output port, so
// the sustained rate is set by that port.
// in_stall rises when the input register holds a byte and the queue has
// fewer than two free entries; a stall on the result side backs up into
// the queue and then into in_stall. in_stall is high during reset.
// reset (synchronous, rst_n low) empties the queue and returns the parser
// to the plain state with the octal value cleared.
module c_escape_unescape (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_end_of_string,
  output logic       out_last_of_run
);
  import ceu_pkg::*;
`include "c_escape_unescape_assert.svh"

  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       room;
  logic       fire;
  dec_out_t   dec;
  res_t       out_res;

  assign fire     = in_vld_r && room;
  assign in_stall = !rst_n || (in_vld_r && !room);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_byte_r <= in_byte;
    end
  end

  ceu_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .in_data (in_byte_r),
    .dec     (dec)
  );

  ceu_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fire),
    .dec       (dec),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_byte          = out_res.data;
  assign out_end_of_string = out_res.eos;
  assign out_last_of_run   = out_res.last;

  `CEU_ASSERT(a_nul_gives_result, clk, rst_n, fire && in_byte_r == CHAR_NUL |-> dec.cnt != 2'd0, "zero byte gave no result")
  `CEU_ASSERT(a_pair_last, clk, rst_n, dec.cnt == 2'd2 |-> dec.r1.last && !dec.r0.last && !dec.r0.eos, "bad last flags on result pair")
  `CEU_ASSERT(a_eos_zero, clk, rst_n, out_valid && out_end_of_string |-> out_byte == CHAR_NUL && out_last_of_run, "terminator not zero or not last")
  `CEU_ASSERT_NR(a_reset_stall, clk, !rst_n |-> in_stall, "input taken during reset")

endmodule
